// ===== rtl/read_quality_adapter_trimmer_core_macros.svh =====
// Assertion macros used by the trimmer back end.
`ifndef READ_QUALITY_ADAPTER_TRIMMER_CORE_MACROS_SVH
`define READ_QUALITY_ADAPTER_TRIMMER_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define RQAT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define RQAT_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/rqat_pkg.sv =====
// Shared types, constants and helpers of the read trimmer.
`default_nettype none
package rqat_pkg;

  localparam int MaxRead    = 256;
  localparam int AddrW      = $clog2(MaxRead);
  localparam int LenW       = AddrW + 1;
  localparam int MaxAdapter = 64;
  localparam int MaxSeed    = 32;

  // base codes
  localparam logic [2:0] BaseA   = 3'd0;
  localparam logic [2:0] BaseC   = 3'd1;
  localparam logic [2:0] BaseG   = 3'd2;
  localparam logic [2:0] BaseT   = 3'd3;
  localparam logic [2:0] BaseBad = 3'd4;

  // result status codes
  localparam logic [2:0] StatKept      = 3'd0;
  localparam logic [2:0] StatAdaptCut  = 3'd1;
  localparam logic [2:0] StatTailCut   = 3'd2;
  localparam logic [2:0] StatQualDrop  = 3'd3;
  localparam logic [2:0] StatAdaptDrop = 3'd4;
  localparam logic [2:0] StatTailDrop  = 3'd5;

  typedef enum logic [2:0] {
    CfgMinLen    = 3'd0,
    CfgMinQual   = 3'd1,
    CfgAdaptLo   = 3'd2,
    CfgAdaptHi   = 3'd3,
    CfgAdaptLen  = 3'd4,
    CfgSeed      = 3'd5,
    CfgSeedLen   = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    SIdle, SQrd, SQchk, SLchk, SSbeg, SSrd, SSchk, STrd0, STrd1, STchk, SFin
  } state_e;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic            ovf;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [10:0]      data;  // {base code, quality}
  } wr_t;

  typedef struct packed {
    logic [8:0]   min_len;
    logic [7:0]   min_q;
    logic [127:0] adapter;
    logic [6:0]   al;   // clamped adapter length
    logic [63:0]  seed;
    logic [5:0]   sl;   // clamped seed length
  } cfg_t;

  function automatic logic [2:0] base_code(input logic [7:0] c);
    logic [2:0] r;
    unique case (c)
      8'h41:   r = BaseA;
      8'h43:   r = BaseC;
      8'h47:   r = BaseG;
      8'h54:   r = BaseT;
      default: r = BaseBad;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rqat_front.sv =====
// Front end: takes bases, codes them, fills the read buffer, posts jobs.
`default_nettype none
module rqat_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          base_char_i,
  input  wire logic [7:0]          quality_char_i,
  input  wire logic                last_base_i,
  input  wire logic                q_full_i,
  input  wire logic                release_i,
  output logic                     push_o,
  output rqat_pkg::job_t           job_o,
  output rqat_pkg::wr_t            wr_o
);

  logic [rqat_pkg::LenW-1:0] fill_q, fill_d, fill_inc;
  logic ovf_q, ovf_d, busy_q, busy_d;
  logic acc, room;

  assign in_stall_o = busy_q | q_full_i;
  assign acc        = in_valid_i & ~in_stall_o;
  assign room       = fill_q < rqat_pkg::LenW'(rqat_pkg::MaxRead);
  assign fill_inc   = room ? fill_q + 1'b1 : fill_q;

  assign wr_o.en   = acc & room;
  assign wr_o.addr = fill_q[rqat_pkg::AddrW-1:0];
  assign wr_o.data = {rqat_pkg::base_code(base_char_i), quality_char_i};

  assign push_o    = acc & last_base_i;
  assign job_o.len = fill_inc;
  assign job_o.ovf = ovf_q | ~room;

  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    busy_d = busy_q;
    if (release_i) busy_d = 1'b0;
    if (acc) begin
      if (last_base_i) begin
        fill_d = '0;
        ovf_d  = 1'b0;
        busy_d = 1'b1;  // buffer belongs to the back end until released
      end else begin
        fill_d = fill_inc;
        ovf_d  = ovf_q | ~room;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      busy_q <= busy_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rqat_jobq.sv =====
// Two-entry job queue between front and back end.
`default_nettype none
module rqat_jobq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rqat_pkg::job_t job_i,
  input  wire logic           pop_i,
  output rqat_pkg::job_t      job_o,
  output logic                full_o,
  output logic                empty_o
);

  rqat_pkg::job_t slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) slot_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rqat_back.sv =====
// Back end: read buffer, quality trim, seed/adapter search, tail check, result.
`default_nettype none
`include "read_quality_adapter_trimmer_core_macros.svh"
module rqat_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rqat_pkg::cfg_t cfg_i,
  input  wire rqat_pkg::wr_t  wr_i,
  input  wire logic           q_empty_i,
  input  wire rqat_pkg::job_t job_i,
  output logic                pop_o,
  output logic                release_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [8:0]          kept_length_o,
  output logic [2:0]          trim_status_o,
  output logic                overflowed_o
);

  localparam int LenW  = rqat_pkg::LenW;
  localparam int AddrW = rqat_pkg::AddrW;

  logic [10:0] mem_q [rqat_pkg::MaxRead];
  logic [10:0] rd_data_q;
  logic [AddrW-1:0] rd_addr;

  rqat_pkg::state_e state_q, state_d;
  logic [LenW-1:0] i_q, i_d, len_q, len_d, pos_q, pos_d, res_len_q, res_len_d;
  logic [2:0] res_st_q, res_st_d;
  logic [6:0] k_q, k_d, mis_q, mis_d, n_q, n_d, lim_q, lim_d;
  logic [4:0] allw_q, allw_d;
  logic ovf_q, ovf_d, m0_q, m0_d;
  logic ovalid_q, kept_ovf_q;
  logic [8:0] kept_q;
  logic [2:0] st_q;

  logic [2:0] rd_code;
  logic q_good, seed_past, seed_mis, adap_mis, pos_fail, k_last, out_free, m1;
  logic [LenW:0] seed_end, sum_pk;
  logic [LenW-1:0] rem;
  logic [6:0] n_calc, mis_nxt;
  logic [1:0] seed_b, adap_b;

  assign rd_code   = rd_data_q[10:8];
  assign q_good    = rd_data_q[7:0] >= cfg_i.min_q;
  assign seed_end  = (LenW+1)'(pos_q) + (LenW+1)'(cfg_i.sl);
  assign seed_past = seed_end > (LenW+1)'(len_q);
  assign rem       = len_q - pos_q;
  assign n_calc    = (rem > LenW'(cfg_i.al)) ? cfg_i.al : rem[6:0];
  assign seed_b    = cfg_i.seed[{k_q[4:0], 1'b0} +: 2];
  assign adap_b    = cfg_i.adapter[{k_q[5:0], 1'b0} +: 2];
  assign seed_mis  = (k_q < 7'(cfg_i.sl)) && (rd_code != {1'b0, seed_b});
  assign adap_mis  = (k_q < n_q) && (rd_code != {1'b0, adap_b});
  assign mis_nxt   = mis_q + 7'(adap_mis);
  assign pos_fail  = seed_mis || (mis_nxt > 7'(allw_q));
  assign k_last    = (k_q + 7'd1) >= lim_q;
  assign out_free  = !ovalid_q || !out_stall_i;
  assign m1        = rd_code == {1'b0, cfg_i.adapter[3:2]};
  assign sum_pk    = (LenW+1)'(pos_q) + (LenW+1)'(k_q);

  always_comb begin
    unique case (state_q)
      rqat_pkg::SSrd:  rd_addr = sum_pk[AddrW-1:0];
      rqat_pkg::STrd0: rd_addr = AddrW'(len_q - LenW'(2));
      rqat_pkg::STrd1: rd_addr = AddrW'(len_q - LenW'(1));
      default:         rd_addr = i_q[AddrW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr] <= wr_i.data;
    rd_data_q <= mem_q[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rqat_pkg::SIdle:
        if (!q_empty_i) state_d = (job_i.len == LenW'(1)) ? rqat_pkg::SLchk : rqat_pkg::SQrd;
      rqat_pkg::SQrd:  state_d = rqat_pkg::SQchk;
      rqat_pkg::SQchk:
        state_d = (q_good || i_q == LenW'(1)) ? rqat_pkg::SLchk : rqat_pkg::SQrd;
      rqat_pkg::SLchk:
        state_d = (len_q < cfg_i.min_len) ? rqat_pkg::SFin : rqat_pkg::SSbeg;
      rqat_pkg::SSbeg: begin
        if (seed_past) state_d = (len_q >= LenW'(2)) ? rqat_pkg::STrd0 : rqat_pkg::SFin;
        else state_d = rqat_pkg::SSrd;
      end
      rqat_pkg::SSrd:  state_d = rqat_pkg::SSchk;
      rqat_pkg::SSchk: begin
        if (pos_fail) state_d = rqat_pkg::SSbeg;
        else if (k_last) state_d = rqat_pkg::SFin;
        else state_d = rqat_pkg::SSrd;
      end
      rqat_pkg::STrd0: state_d = rqat_pkg::STrd1;
      rqat_pkg::STrd1: state_d = rqat_pkg::STchk;
      rqat_pkg::STchk: state_d = rqat_pkg::SFin;
      rqat_pkg::SFin:  if (out_free) state_d = rqat_pkg::SIdle;
      default:         state_d = rqat_pkg::SIdle;
    endcase
  end

  // datapath and strobes
  always_comb begin
    i_d = i_q; len_d = len_q; pos_d = pos_q; k_d = k_q; mis_d = mis_q;
    n_d = n_q; lim_d = lim_q; allw_d = allw_q; ovf_d = ovf_q; m0_d = m0_q;
    res_len_d = res_len_q; res_st_d = res_st_q;
    pop_o = 1'b0;
    release_o = 1'b0;
    unique case (state_q)
      rqat_pkg::SIdle: begin
        pop_o = !q_empty_i;
        len_d = job_i.len;
        i_d   = job_i.len - LenW'(1);
        ovf_d = job_i.ovf;
      end
      rqat_pkg::SQchk: begin
        if (q_good) len_d = i_q + LenW'(1);
        else if (i_q == LenW'(1)) len_d = LenW'(1);
        i_d = i_q - LenW'(1);
      end
      rqat_pkg::SLchk: begin
        pos_d     = '0;
        res_len_d = '0;
        res_st_d  = rqat_pkg::StatQualDrop;
      end
      rqat_pkg::SSbeg: begin
        k_d       = '0;
        mis_d     = '0;
        n_d       = n_calc;
        allw_d    = 5'((8'(n_calc) + 8'd3) >> 2);
        lim_d     = (7'(cfg_i.sl) > n_calc) ? 7'(cfg_i.sl) : n_calc;
        res_len_d = len_q;
        res_st_d  = rqat_pkg::StatKept;
      end
      rqat_pkg::SSchk: begin
        mis_d = mis_nxt;
        k_d   = k_q + 7'd1;
        if (pos_fail) begin
          pos_d = pos_q + LenW'(1);
        end else if (pos_q >= cfg_i.min_len) begin
          res_len_d = pos_q;
          res_st_d  = rqat_pkg::StatAdaptCut;
        end else begin
          res_len_d = '0;
          res_st_d  = rqat_pkg::StatAdaptDrop;
        end
      end
      rqat_pkg::STrd1: m0_d = rd_code == {1'b0, cfg_i.adapter[1:0]};
      rqat_pkg::STchk: begin
        if (m0_q && m1) begin
          if ((len_q - LenW'(2)) < cfg_i.min_len) begin
            res_len_d = '0;
            res_st_d  = rqat_pkg::StatTailDrop;
          end else begin
            res_len_d = len_q - LenW'(2);
            res_st_d  = rqat_pkg::StatTailCut;
          end
        end else begin
          res_len_d = len_q;
          res_st_d  = rqat_pkg::StatKept;
        end
      end
      rqat_pkg::SFin: release_o = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rqat_pkg::SIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= release_o | (ovalid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; len_q <= len_d; pos_q <= pos_d; k_q <= k_d; mis_q <= mis_d;
    n_q <= n_d; lim_q <= lim_d; allw_q <= allw_d; ovf_q <= ovf_d; m0_q <= m0_d;
    res_len_q <= res_len_d; res_st_q <= res_st_d;
    if (release_o) begin
      kept_q     <= 9'(res_len_q);
      st_q       <= res_st_q;
      kept_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign kept_length_o = kept_q;
  assign trim_status_o = st_q;
  assign overflowed_o  = kept_ovf_q;

  `RQAT_ASSERT(a_trim_idx_nonzero, (state_q == rqat_pkg::SQrd) |-> (i_q != '0), "trim index hit 0")
  `RQAT_ASSERT(a_search_in_read, (state_q == rqat_pkg::SSrd) |-> (sum_pk < (LenW+1)'(len_q)), "search past read end")
  `RQAT_ASSERT(a_release_loads_out, release_o |=> out_valid_o, "released without result")
  `RQAT_ASSERT_NR(a_reset_no_out, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule
`default_nettype wire

// ===== rtl/read_quality_adapter_trimmer_core.sv =====
// Read quality and adapter trimmer: top level with configuration registers.
// Bases of a read are taken one per cycle while the input is not stalled into
// a 256-entry buffer. After the beat marked last_base the input stalls until
// the result is in the output register. Processing then scans the read back
// base by base in the quality trim, compares base by base in the seed/adapter
// search with a setup step per start position (each start position compares
// up to max(seed, adapter) bases, stopping at the first mismatch that rules
// it out) and reads the last two bases for the tail check; every step goes
// through the single registered read port of the buffer. Bases beyond 256
// are dropped and reported in overflowed_o.
`default_nettype none
module read_quality_adapter_trimmer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  base_char_i,
  input  wire logic [7:0]  quality_char_i,
  input  wire logic        last_base_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [8:0]       kept_length_o,
  output logic [2:0]       trim_status_o,
  output logic             overflowed_o
);

  logic [8:0]  min_len_q;
  logic [7:0]  min_q_q;
  logic [63:0] adapt_lo_q, adapt_hi_q, seed_q;
  logic [6:0]  adapt_len_q;
  logic [5:0]  seed_len_q;
  rqat_pkg::cfg_idx_e idx;
  rqat_pkg::cfg_t cfg;
  rqat_pkg::job_t push_job, q_job;
  rqat_pkg::wr_t  wr;
  logic push, pop, q_full, q_empty, rel, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = rqat_pkg::cfg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q   <= 9'd36;
      min_q_q     <= 8'd53;
      adapt_lo_q  <= '0;
      adapt_hi_q  <= '0;
      adapt_len_q <= 7'd33;
      seed_q      <= '0;
      seed_len_q  <= 6'd8;
    end else if (wr_en) begin
      unique case (idx)
        rqat_pkg::CfgMinLen:   min_len_q   <= pwdata[8:0];
        rqat_pkg::CfgMinQual:  min_q_q     <= pwdata[7:0];
        rqat_pkg::CfgAdaptLo:  adapt_lo_q  <= pwdata;
        rqat_pkg::CfgAdaptHi:  adapt_hi_q  <= pwdata;
        rqat_pkg::CfgAdaptLen: adapt_len_q <= pwdata[6:0];
        rqat_pkg::CfgSeed:     seed_q      <= pwdata;
        rqat_pkg::CfgSeedLen:  seed_len_q  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rqat_pkg::CfgMinLen:   prdata = 64'(min_len_q);
      rqat_pkg::CfgMinQual:  prdata = 64'(min_q_q);
      rqat_pkg::CfgAdaptLo:  prdata = adapt_lo_q;
      rqat_pkg::CfgAdaptHi:  prdata = adapt_hi_q;
      rqat_pkg::CfgAdaptLen: prdata = 64'(adapt_len_q);
      rqat_pkg::CfgSeed:     prdata = seed_q;
      rqat_pkg::CfgSeedLen:  prdata = 64'(seed_len_q);
      default:               prdata = '0;
    endcase
  end

  // clamp lengths into the supported range
  always_comb begin
    cfg.min_len = min_len_q;
    cfg.min_q   = min_q_q;
    cfg.adapter = {adapt_hi_q, adapt_lo_q};
    cfg.seed    = seed_q;
    if (adapt_len_q < 7'd2) cfg.al = 7'd2;
    else if (adapt_len_q > 7'(rqat_pkg::MaxAdapter)) cfg.al = 7'(rqat_pkg::MaxAdapter);
    else cfg.al = adapt_len_q;
    if (seed_len_q == 6'd0) cfg.sl = 6'd1;
    else if (seed_len_q > 6'(rqat_pkg::MaxSeed)) cfg.sl = 6'(rqat_pkg::MaxSeed);
    else cfg.sl = seed_len_q;
  end

  rqat_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .base_char_i    (base_char_i),
    .quality_char_i (quality_char_i),
    .last_base_i    (last_base_i),
    .q_full_i       (q_full),
    .release_i      (rel),
    .push_o         (push),
    .job_o          (push_job),
    .wr_o           (wr)
  );

  rqat_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (q_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rqat_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .wr_i          (wr),
    .q_empty_i     (q_empty),
    .job_i         (q_job),
    .pop_o         (pop),
    .release_o     (rel),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kept_length_o (kept_length_o),
    .trim_status_o (trim_status_o),
    .overflowed_o  (overflowed_o)
  );

endmodule
`default_nettype wire
